// ===== sv/ptcp_pkg.sv =====
package ptcp_pkg;

   // Coordinate format; the binary point position does not change any bit of the work
   localparam int COORD_W = 32;
   localparam int IN_W = 12 * COORD_W;

   // Exact arithmetic widths
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DOT_W = PROD_W + 2;
   localparam int EDGE_W = DOT_W + 1;
   localparam int CROSS_W = 2 * DOT_W + 1;
   localparam int NUM_W = CROSS_W + DIFF_W + 2;
   localparam int DEN_W = CROSS_W + 2;

   // Split of the wide products into narrow partial products
   localparam int HALF_W = DOT_W / 2;
   localparam int LIMB_W = 35;
   localparam int LIMBS = 4;
   localparam int TOP_LO = (LIMBS - 1) * LIMB_W;

   // Divider widths: rounded quotient of (2|n| + |d|) / (2|d|)
   localparam int NA_W = NUM_W + 2;
   localparam int DA_W = DEN_W + 1;
   localparam int QUO_W = 40;
   localparam int CMP_W = DA_W + QUO_W;
   localparam int SUM_W = QUO_W + 2;

   // Distance widths
   localparam int SQ_W = PROD_W + 2;
   localparam int XW = SQ_W + 1;
   localparam int ROOT_W = SQ_W / 2;
   localparam int GAP_W = 34;
   localparam int RSP_DATA_W = ((3 * COORD_W + GAP_W + 7) / 8) * 8;

   // Pipeline depths
   localparam int FRONT_STAGES = 10;
   localparam int DIV_STAGES = QUO_W + 2;
   localparam int BACK_STAGES = 3 + ROOT_W;

   typedef enum logic [2:0] {
      REGION_VERT_A  = 3'd0,
      REGION_VERT_B  = 3'd1,
      REGION_EDGE_AB = 3'd2,
      REGION_VERT_C  = 3'd3,
      REGION_EDGE_AC = 3'd4,
      REGION_EDGE_BC = 3'd5,
      REGION_INSIDE  = 3'd6
   } region_type;

   typedef logic [2:0][COORD_W-1:0] vec_type;

   typedef struct packed {
      vec_type pt;
      vec_type va;
      vec_type vb;
      vec_type vc;
   } geo_type;

   typedef struct packed {
      vec_type    pt;
      vec_type    base;
      logic       use_base;
      region_type region;
   } side_type;

   function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] v);
      return {v[COORD_W-1], v};
   endfunction

   // Signed upper half of a dot product
   function automatic logic signed [HALF_W-1:0] dot_hi(input logic signed [DOT_W-1:0] v);
      return v[DOT_W-1:HALF_W];
   endfunction

   // Lower half of a dot product, zero-extended
   function automatic logic signed [HALF_W:0] dot_lo(input logic signed [DOT_W-1:0] v);
      return {1'b0, v[HALF_W-1:0]};
   endfunction

endpackage

// ===== sv/ptcp_front.sv =====
module ptcp_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [ptcp_pkg::IN_W-1:0]               in_data,
   output logic                                    out_valid,
   output logic signed [ptcp_pkg::NUM_W-1:0]       numer [3],
   output logic signed [ptcp_pkg::DEN_W-1:0]       den,
   output ptcp_pkg::side_type                      side
);

   localparam int DIFF_W = ptcp_pkg::DIFF_W;
   localparam int PROD_W = ptcp_pkg::PROD_W;
   localparam int DOT_W = ptcp_pkg::DOT_W;
   localparam int EDGE_W = ptcp_pkg::EDGE_W;
   localparam int CROSS_W = ptcp_pkg::CROSS_W;
   localparam int NUM_W = ptcp_pkg::NUM_W;
   localparam int DEN_W = ptcp_pkg::DEN_W;
   localparam int HALF_W = ptcp_pkg::HALF_W;
   localparam int LIMB_W = ptcp_pkg::LIMB_W;
   localparam int LIMBS = ptcp_pkg::LIMBS;
   localparam int TOP_LO = ptcp_pkg::TOP_LO;
   localparam int CRP_W = 2 * DOT_W;
   localparam int CW = ptcp_pkg::COORD_W;

   logic [ptcp_pkg::FRONT_STAGES-1:0] vld_ff;

   ptcp_pkg::geo_type g_in, g1_ff, g2_ff, g3_ff, g4_ff, g5_ff, g6_ff;
   logic signed [DIFF_W-1:0] ab1_ff [3], ac1_ff [3], ap1_ff [3], bp1_ff [3], cp1_ff [3];
   logic signed [PROD_W-1:0] pr2_ff [6][3];
   logic signed [DOT_W-1:0] d3_ff [6], d4_ff [6], d5_ff [6], d6_ff [6];
   logic signed [DOT_W-1:0] cx [6], cy [6];
   logic signed [CRP_W-1:0] pp4_ff [6][4];
   logic signed [CRP_W-1:0] cr5_ff [6];
   logic signed [CROSS_W-1:0] va6_ff, vb6_ff, vc6_ff;

   logic signed [CROSS_W-1:0] m1_in, m2_in, m1_ff, m2_ff;
   logic signed [DIFF_W-1:0] dir1_in [3], dir2_in [3], dir1_ff [3], dir2_ff [3];
   logic signed [DEN_W-1:0] den_in, den7_ff, den8_ff, den9_ff, den10_ff;
   ptcp_pkg::side_type side_in, side7_ff, side8_ff, side9_ff, side10_ff;
   logic signed [NUM_W-1:0] pq8_ff [2][3][LIMBS];
   logic signed [NUM_W-1:0] p9_ff [2][3], num10_ff [3];
   logic signed [EDGE_W-1:0] e43, e56;
   logic signed [DIFF_W-1:0] ab6 [3], ac6 [3], bc6 [3];

   assign g_in.pt = in_data[0 +: 3*CW];
   assign g_in.va = in_data[3*CW +: 3*CW];
   assign g_in.vb = in_data[6*CW +: 3*CW];
   assign g_in.vc = in_data[9*CW +: 3*CW];

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ptcp_pkg::FRONT_STAGES-2:0], in_valid};
      end
   end

   // Pair the dot products of each cross term
   always_comb begin
      cx[0] = d3_ff[0]; cy[0] = d3_ff[3];
      cx[1] = d3_ff[2]; cy[1] = d3_ff[1];
      cx[2] = d3_ff[4]; cy[2] = d3_ff[1];
      cx[3] = d3_ff[0]; cy[3] = d3_ff[5];
      cx[4] = d3_ff[2]; cy[4] = d3_ff[5];
      cx[5] = d3_ff[4]; cy[5] = d3_ff[3];
   end

   // Stages one to six: edge vectors, dot products and cross terms
   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff <= g_in;
         g2_ff <= g1_ff;
         g3_ff <= g2_ff;
         g4_ff <= g3_ff;
         g5_ff <= g4_ff;
         g6_ff <= g5_ff;
         for (int k = 0; k < 3; k++) begin
            ab1_ff[k] <= ptcp_pkg::sx(g_in.vb[k]) - ptcp_pkg::sx(g_in.va[k]);
            ac1_ff[k] <= ptcp_pkg::sx(g_in.vc[k]) - ptcp_pkg::sx(g_in.va[k]);
            ap1_ff[k] <= ptcp_pkg::sx(g_in.pt[k]) - ptcp_pkg::sx(g_in.va[k]);
            bp1_ff[k] <= ptcp_pkg::sx(g_in.pt[k]) - ptcp_pkg::sx(g_in.vb[k]);
            cp1_ff[k] <= ptcp_pkg::sx(g_in.pt[k]) - ptcp_pkg::sx(g_in.vc[k]);
            pr2_ff[0][k] <= PROD_W'(ab1_ff[k] * ap1_ff[k]);
            pr2_ff[1][k] <= PROD_W'(ac1_ff[k] * ap1_ff[k]);
            pr2_ff[2][k] <= PROD_W'(ab1_ff[k] * bp1_ff[k]);
            pr2_ff[3][k] <= PROD_W'(ac1_ff[k] * bp1_ff[k]);
            pr2_ff[4][k] <= PROD_W'(ab1_ff[k] * cp1_ff[k]);
            pr2_ff[5][k] <= PROD_W'(ac1_ff[k] * cp1_ff[k]);
         end
         for (int j = 0; j < 6; j++) begin
            d3_ff[j] <= DOT_W'(pr2_ff[j][0] + pr2_ff[j][1] + pr2_ff[j][2]);
            // half by half partial products of the cross terms
            pp4_ff[j][0] <= CRP_W'(ptcp_pkg::dot_hi(cx[j]) * ptcp_pkg::dot_hi(cy[j]))
                            <<< (2 * HALF_W);
            pp4_ff[j][1] <= CRP_W'(ptcp_pkg::dot_hi(cx[j]) * ptcp_pkg::dot_lo(cy[j]))
                            <<< HALF_W;
            pp4_ff[j][2] <= CRP_W'(ptcp_pkg::dot_lo(cx[j]) * ptcp_pkg::dot_hi(cy[j]))
                            <<< HALF_W;
            pp4_ff[j][3] <= CRP_W'(ptcp_pkg::dot_lo(cx[j]) * ptcp_pkg::dot_lo(cy[j]));
            cr5_ff[j] <= pp4_ff[j][0] + pp4_ff[j][1] + pp4_ff[j][2] + pp4_ff[j][3];
         end
         d4_ff <= d3_ff;
         d5_ff <= d4_ff;
         d6_ff <= d5_ff;
         vc6_ff <= CROSS_W'(cr5_ff[0] - cr5_ff[1]);
         vb6_ff <= CROSS_W'(cr5_ff[2] - cr5_ff[3]);
         va6_ff <= CROSS_W'(cr5_ff[4] - cr5_ff[5]);
      end
   end

   // Classify the point and pick the weight terms of its region
   always_comb begin
      e43 = EDGE_W'(d6_ff[3] - d6_ff[2]);
      e56 = EDGE_W'(d6_ff[4] - d6_ff[5]);
      for (int k = 0; k < 3; k++) begin
         ab6[k] = ptcp_pkg::sx(g6_ff.vb[k]) - ptcp_pkg::sx(g6_ff.va[k]);
         ac6[k] = ptcp_pkg::sx(g6_ff.vc[k]) - ptcp_pkg::sx(g6_ff.va[k]);
         bc6[k] = ptcp_pkg::sx(g6_ff.vc[k]) - ptcp_pkg::sx(g6_ff.vb[k]);
         dir1_in[k] = '0;
         dir2_in[k] = '0;
      end
      m1_in = '0;
      m2_in = '0;
      den_in = '0;
      side_in.pt = g6_ff.pt;
      side_in.base = g6_ff.va;
      side_in.use_base = 1'b1;
      side_in.region = ptcp_pkg::REGION_VERT_A;
      if ((d6_ff[0][DOT_W-1] || d6_ff[0] == '0) && (d6_ff[1][DOT_W-1] || d6_ff[1] == '0)) begin
         side_in.region = ptcp_pkg::REGION_VERT_A;
      end else if (!d6_ff[2][DOT_W-1] && (e43[EDGE_W-1] || e43 == '0)) begin
         side_in.region = ptcp_pkg::REGION_VERT_B;
         side_in.base = g6_ff.vb;
      end else if ((vc6_ff[CROSS_W-1] || vc6_ff == '0) && !d6_ff[0][DOT_W-1] &&
                   (d6_ff[2][DOT_W-1] || d6_ff[2] == '0)) begin
         side_in.region = ptcp_pkg::REGION_EDGE_AB;
         side_in.use_base = 1'b0;
         m1_in = CROSS_W'(d6_ff[0]);
         dir1_in = ab6;
         den_in = DEN_W'(d6_ff[0] - d6_ff[2]);
      end else if (!d6_ff[5][DOT_W-1] && (e56[EDGE_W-1] || e56 == '0)) begin
         side_in.region = ptcp_pkg::REGION_VERT_C;
         side_in.base = g6_ff.vc;
      end else if ((vb6_ff[CROSS_W-1] || vb6_ff == '0) && !d6_ff[1][DOT_W-1] &&
                   (d6_ff[5][DOT_W-1] || d6_ff[5] == '0)) begin
         side_in.region = ptcp_pkg::REGION_EDGE_AC;
         side_in.use_base = 1'b0;
         m1_in = CROSS_W'(d6_ff[1]);
         dir1_in = ac6;
         den_in = DEN_W'(d6_ff[1] - d6_ff[5]);
      end else if ((va6_ff[CROSS_W-1] || va6_ff == '0) && !e43[EDGE_W-1] &&
                   !e56[EDGE_W-1]) begin
         side_in.region = ptcp_pkg::REGION_EDGE_BC;
         side_in.use_base = 1'b0;
         side_in.base = g6_ff.vb;
         m1_in = CROSS_W'(e43);
         dir1_in = bc6;
         den_in = DEN_W'(e43 + e56);
      end else begin
         side_in.region = ptcp_pkg::REGION_INSIDE;
         side_in.use_base = 1'b0;
         m1_in = vb6_ff;
         dir1_in = ab6;
         m2_in = vc6_ff;
         dir2_in = ac6;
         den_in = DEN_W'(va6_ff + vb6_ff + vc6_ff);
      end
   end

   // Stages seven to ten: register the selection, scale the directions limb by limb, sum
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         dir1_ff <= dir1_in;
         dir2_ff <= dir2_in;
         den7_ff <= den_in;
         side7_ff <= side_in;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < LIMBS - 1; i++) begin
               pq8_ff[0][k][i] <= NUM_W'($signed({1'b0, m1_ff[i*LIMB_W +: LIMB_W]})
                                         * dir1_ff[k]) <<< (i * LIMB_W);
               pq8_ff[1][k][i] <= NUM_W'($signed({1'b0, m2_ff[i*LIMB_W +: LIMB_W]})
                                         * dir2_ff[k]) <<< (i * LIMB_W);
            end
            pq8_ff[0][k][LIMBS-1] <= NUM_W'($signed(m1_ff[CROSS_W-1:TOP_LO]) * dir1_ff[k])
                                     <<< TOP_LO;
            pq8_ff[1][k][LIMBS-1] <= NUM_W'($signed(m2_ff[CROSS_W-1:TOP_LO]) * dir2_ff[k])
                                     <<< TOP_LO;
            p9_ff[0][k] <= pq8_ff[0][k][0] + pq8_ff[0][k][1] + pq8_ff[0][k][2]
                           + pq8_ff[0][k][3];
            p9_ff[1][k] <= pq8_ff[1][k][0] + pq8_ff[1][k][1] + pq8_ff[1][k][2]
                           + pq8_ff[1][k][3];
            num10_ff[k] <= p9_ff[0][k] + p9_ff[1][k];
         end
         den8_ff <= den7_ff;
         side8_ff.pt <= side7_ff.pt;
         side8_ff.base <= side7_ff.base;
         side8_ff.region <= side7_ff.region;
         // a zero divisor falls back to the base point
         side8_ff.use_base <= side7_ff.use_base || den7_ff == '0;
         den9_ff <= den8_ff;
         side9_ff <= side8_ff;
         den10_ff <= den9_ff;
         side10_ff <= side9_ff;
      end
   end

   assign out_valid = vld_ff[ptcp_pkg::FRONT_STAGES-1];
   assign numer = num10_ff;
   assign den = den10_ff;
   assign side = side10_ff;

endmodule

// ===== sv/ptcp_divide.sv =====
module ptcp_divide (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [ptcp_pkg::NUM_W-1:0]  numer [3],
   input  logic signed [ptcp_pkg::DEN_W-1:0]  den,
   input  ptcp_pkg::side_type                 side,
   output logic                               out_valid,
   output ptcp_pkg::vec_type                  near,
   output ptcp_pkg::side_type                 side_out
);

   localparam int NUM_W = ptcp_pkg::NUM_W;
   localparam int DEN_W = ptcp_pkg::DEN_W;
   localparam int NA_W = ptcp_pkg::NA_W;
   localparam int DA_W = ptcp_pkg::DA_W;
   localparam int QUO_W = ptcp_pkg::QUO_W;
   localparam int CMP_W = ptcp_pkg::CMP_W;
   localparam int SUM_W = ptcp_pkg::SUM_W;
   localparam int CW = ptcp_pkg::COORD_W;
   localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

   logic [ptcp_pkg::DIV_STAGES-1:0] vld_ff;
   logic [CMP_W-1:0] rem_ff [QUO_W+1][3];
   logic [QUO_W-1:0] quo_ff [QUO_W+1][3];
   logic [2:0] neg_ff [QUO_W+1];
   logic [2:0] ovf_ff [QUO_W+1];
   logic [DA_W-1:0] dd_ff [QUO_W+1];
   ptcp_pkg::side_type sd_ff [QUO_W+1];

   logic [NUM_W-1:0] an [3];
   logic [DEN_W-1:0] ad;
   logic [NA_W-1:0] nn [3];
   logic [DA_W-1:0] dd;
   ptcp_pkg::vec_type near_ff;
   ptcp_pkg::side_type side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ptcp_pkg::DIV_STAGES-2:0], in_valid};
      end
   end

   // Take magnitudes and form the rounding dividend and divisor
   always_comb begin
      ad = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      dd = DA_W'(ad) << 1;
      for (int k = 0; k < 3; k++) begin
         an[k] = numer[k][NUM_W-1] ? NUM_W'(-numer[k]) : NUM_W'(numer[k]);
         nn[k] = (NA_W'(an[k]) << 1) + NA_W'(ad);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff[0] <= dd;
         sd_ff[0] <= side;
         for (int k = 0; k < 3; k++) begin
            rem_ff[0][k] <= CMP_W'(nn[k]);
            quo_ff[0][k] <= '0;
            neg_ff[0][k] <= numer[k][NUM_W-1] ^ den[DEN_W-1];
            // a quotient past the kept bits saturates anyway
            ovf_ff[0][k] <= CMP_W'(nn[k]) >= (CMP_W'(dd) << QUO_W);
         end
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int B = QUO_W - 1 - j;
      always_ff @(posedge clock) begin
         if (en) begin
            dd_ff[j+1] <= dd_ff[j];
            sd_ff[j+1] <= sd_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
            for (int k = 0; k < 3; k++) begin
               if (rem_ff[j][k] >= (CMP_W'(dd_ff[j]) << B)) begin
                  rem_ff[j+1][k] <= rem_ff[j][k] - (CMP_W'(dd_ff[j]) << B);
                  quo_ff[j+1][k] <= quo_ff[j][k] | (QUO_W'(1) << B);
               end else begin
                  rem_ff[j+1][k] <= rem_ff[j][k];
                  quo_ff[j+1][k] <= quo_ff[j][k];
               end
            end
         end
      end
   end

   // Pass the base point through, or add the signed offset to it and clamp to the coordinate range
   always_ff @(posedge clock) begin
      logic signed [SUM_W-1:0] off, sum;
      if (en) begin
         side_ff <= sd_ff[QUO_W];
         for (int k = 0; k < 3; k++) begin
            off = neg_ff[QUO_W][k] ? -$signed(SUM_W'(quo_ff[QUO_W][k]))
                                   : $signed(SUM_W'(quo_ff[QUO_W][k]));
            sum = SUM_W'(ptcp_pkg::sx(sd_ff[QUO_W].base[k])) + off;
            if (sd_ff[QUO_W].use_base) begin
               near_ff[k] <= sd_ff[QUO_W].base[k];
            end else if (ovf_ff[QUO_W][k]) begin
               near_ff[k] <= neg_ff[QUO_W][k] ? CW'(LO) : CW'(HI);
            end else if (sum > HI) begin
               near_ff[k] <= CW'(HI);
            end else if (sum < LO) begin
               near_ff[k] <= CW'(LO);
            end else begin
               near_ff[k] <= CW'(sum);
            end
         end
      end
   end

   assign out_valid = vld_ff[ptcp_pkg::DIV_STAGES-1];
   assign near = near_ff;
   assign side_out = side_ff;

endmodule

// ===== sv/ptcp_back.sv =====
module ptcp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  ptcp_pkg::vec_type                 near,
   input  ptcp_pkg::side_type                side,
   output logic                              out_valid,
   output ptcp_pkg::vec_type                 near_out,
   output ptcp_pkg::region_type              region,
   output logic [ptcp_pkg::GAP_W-1:0]        gap
);

   localparam int DIFF_W = ptcp_pkg::DIFF_W;
   localparam int PROD_W = ptcp_pkg::PROD_W;
   localparam int SQ_W = ptcp_pkg::SQ_W;
   localparam int XW = ptcp_pkg::XW;
   localparam int ROOT_W = ptcp_pkg::ROOT_W;

   logic [ptcp_pkg::BACK_STAGES-1:0] vld_ff;
   logic signed [DIFF_W-1:0] dif_ff [3];
   logic signed [PROD_W-1:0] sq_ff [3];
   ptcp_pkg::vec_type nr_a_ff, nr_b_ff;
   ptcp_pkg::region_type rg_a_ff, rg_b_ff;
   logic [XW-1:0] x_ff [ROOT_W+1];
   logic [XW-1:0] r_ff [ROOT_W+1];
   ptcp_pkg::vec_type nr_ff [ROOT_W+1];
   ptcp_pkg::region_type rg_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ptcp_pkg::BACK_STAGES-2:0], in_valid};
      end
   end

   // Difference, square, sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         nr_a_ff <= near;
         rg_a_ff <= side.region;
         nr_b_ff <= nr_a_ff;
         rg_b_ff <= rg_a_ff;
         for (int k = 0; k < 3; k++) begin
            dif_ff[k] <= ptcp_pkg::sx(side.pt[k]) - ptcp_pkg::sx(near[k]);
            sq_ff[k] <= dif_ff[k] * dif_ff[k];
         end
         x_ff[0] <= XW'(SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]));
         r_ff[0] <= '0;
         nr_ff[0] <= nr_b_ff;
         rg_ff[0] <= rg_b_ff;
      end
   end

   // Integer square root, one root bit per stage
   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      localparam logic [XW-1:0] BIT = XW'(1) << (2 * (ROOT_W - 1 - j));
      always_ff @(posedge clock) begin
         if (en) begin
            nr_ff[j+1] <= nr_ff[j];
            rg_ff[j+1] <= rg_ff[j];
            if (x_ff[j] >= r_ff[j] + BIT) begin
               x_ff[j+1] <= x_ff[j] - (r_ff[j] + BIT);
               r_ff[j+1] <= (r_ff[j] >> 1) + BIT;
            end else begin
               x_ff[j+1] <= x_ff[j];
               r_ff[j+1] <= r_ff[j] >> 1;
            end
         end
      end
   end

   assign out_valid = vld_ff[ptcp_pkg::BACK_STAGES-1];
   assign near_out = nr_ff[ROOT_W];
   assign region = rg_ff[ROOT_W];
   // the root of a sum of three 66-bit squares stays below the field maximum
   assign gap = r_ff[ROOT_W][ptcp_pkg::GAP_W-1:0];

endmodule

// ===== sv/point_triangle_closest_point.sv =====
// Closest point on a triangle to a query point, signed fixed point.
// Request channel (req_): one query per transfer, point P and vertices A, B, C.
// Response channel (rsp_): closest point, distance and Voronoi region code.
// Throughput: one request per cycle while the receiver does not stall, fully pipelined.
// Pipeline: dot and cross products, classification and weighting (wide
// products split into partial products over two stages), then the divider
// (set-up, one quotient bit per stage over 40 bits, then clamp), then the
// distance (difference, square and sum stages, then one root bit per stage
// over 34 bits).
// Reset clears all valid bits; no request in flight survives reset.
// When the receiver stalls, the whole pipeline holds and req_tready drops in
// the same cycle; nothing in flight is lost or repeated.
// Region codes: vertex A = 0, vertex B = 1, edge AB = 2, vertex C = 3, edge AC = 4,
// edge BC = 5, interior = 6. A degenerate triangle gives the base point of the
// case; coordinates clamp to the signed range.
module point_triangle_closest_point (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
   input  logic [ptcp_pkg::IN_W-1:0]           req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // near_x, near_y, near_z, gap_length, zero fill
   output logic [ptcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // region_code
   output logic [2:0]                          rsp_tuser
);

   logic en;
   logic f_valid, d_valid;
   logic signed [ptcp_pkg::NUM_W-1:0] f_numer [3];
   logic signed [ptcp_pkg::DEN_W-1:0] f_den;
   ptcp_pkg::side_type f_side, d_side;
   ptcp_pkg::vec_type d_near, b_near;
   ptcp_pkg::region_type b_region;
   logic [ptcp_pkg::GAP_W-1:0] b_gap;

   // Advance the pipeline unless a response waits
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   ptcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .numer     (f_numer),
      .den       (f_den),
      .side      (f_side)
   );

   ptcp_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .numer     (f_numer),
      .den       (f_den),
      .side      (f_side),
      .out_valid (d_valid),
      .near      (d_near),
      .side_out  (d_side)
   );

   ptcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .near      (d_near),
      .side      (d_side),
      .out_valid (rsp_tvalid),
      .near_out  (b_near),
      .region    (b_region),
      .gap       (b_gap)
   );

   assign rsp_tdata = {{(ptcp_pkg::RSP_DATA_W - 3*ptcp_pkg::COORD_W - ptcp_pkg::GAP_W){1'b0}},
                       b_gap, b_near};
   assign rsp_tuser = b_region;

endmodule

// ===== sv/ptcp_checker.sv =====
module ptcp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ptcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [2:0]                          rsp_tuser
);

   // A stalled response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Reset empties the pipeline
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response blocks new requests
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline stalled");

   // Region code and fill bits stay in range
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 3'd7 &&
      rsp_tdata[ptcp_pkg::RSP_DATA_W-1:3*ptcp_pkg::COORD_W+ptcp_pkg::GAP_W] == '0)
      else $error("bad region code or fill bits");

endmodule

bind point_triangle_closest_point ptcp_checker u_checker (.*);
